FILE: sv/klex_pkg.sv
// klex_pkg: shared types, constants and character helpers for the keyword token lexer
// used by klex_ctrl, klex_dp and keyword_token_lexer; depends on nothing else
package klex_pkg;

  localparam int MAX_WORD = 32;
  localparam int LEN_W    = $clog2(MAX_WORD + 1);
  localparam int ADDR_W   = $clog2(MAX_WORD);

  typedef enum logic [3:0] {
    TK_EXIT, TK_VAR, TK_INT, TK_IDENT, TK_INTLIT, TK_SEMI, TK_LPAREN,
    TK_RPAREN, TK_EQ, TK_COLON, TK_PLUS, TK_ERROR, TK_END
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE, MODE_WORD, MODE_NUM
  } mode_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch;     // take the word on the input channel
    logic append;    // extend the pending word with the held byte
    logic idx_clr;   // restart the replay index
    logic rd_en;     // read the word store at the replay index
    logic emit_kw;   // send a keyword token
    logic emit_ch;   // send one buffered character
    logic tail;      // finish the held byte: clear word, start/emit/halt
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_end;
    logic halted;
    logic extend;
    logic mode_idle;
    logic kw_hit;
    logic ch_last;
    logic tail_emits;
    logic out_free;
  } stat_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_single(logic [7:0] c);
    return c == ";" || c == "(" || c == ")" || c == "=" || c == ":" || c == "+";
  endfunction

  function automatic kind_t single_kind(logic [7:0] c);
    kind_t k;
    case (c)
      ";":     k = TK_SEMI;
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      "=":     k = TK_EQ;
      ":":     k = TK_COLON;
      "+":     k = TK_PLUS;
      default: k = TK_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic kw_exit_at(logic [LEN_W-1:0] pos, logic [7:0] c);
    return (pos == LEN_W'(0) && c == "e") || (pos == LEN_W'(1) && c == "x") ||
           (pos == LEN_W'(2) && c == "i") || (pos == LEN_W'(3) && c == "t");
  endfunction

  function automatic logic kw_var_at(logic [LEN_W-1:0] pos, logic [7:0] c);
    return (pos == LEN_W'(0) && c == "v") || (pos == LEN_W'(1) && c == "a") ||
           (pos == LEN_W'(2) && c == "r");
  endfunction

  function automatic logic kw_int_at(logic [LEN_W-1:0] pos, logic [7:0] c);
    return (pos == LEN_W'(0) && c == "i") || (pos == LEN_W'(1) && c == "n") ||
           (pos == LEN_W'(2) && c == "t");
  endfunction

endpackage

FILE: sv/keyword_token_lexer.sv
// Keyword token lexer: turns a byte stream of source text into tokens. One byte is taken per
// input word; in_tlast, or a zero byte, ends the text, flushes any pending word, gives an end
// token and returns the block to its reset state. A byte that extends a word or number, or one
// dropped after an error, is done in the decide state; any other byte also passes the tail state.
// A byte that closes a word first sends a keyword token or replays the word; the word store has one read port and
// each character is read, then sent. Result words wait in an output register and the next
// result waits only when that register is full and not being taken. Words
// longer than MAX_WORD characters keep their first MAX_WORD characters and are flagged as
// truncated. After an error token further bytes are dropped until the end of text.
// depends on klex_pkg, klex_ctrl and klex_dp
module keyword_token_lexer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_byte
  input  logic       in_tlast,   // is_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] text_char
  output logic [6:0] out_tuser,  // [3:0] token_kind, [4] has_text, [5] truncated, [6] item_last
  output logic       out_tlast   // token_last
);
  import klex_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  kind_t kind;
  logic  has_text, truncated, item_last;

  klex_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  klex_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_byte        (in_tdata),
    .in_end         (in_tlast),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_kind       (kind),
    .out_char       (out_tdata),
    .out_has_text   (has_text),
    .out_token_last (out_tlast),
    .out_truncated  (truncated),
    .out_item_last  (item_last)
  );

  assign out_tuser = {item_last, truncated, has_text, kind};

  // at most one result source per cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_kw, cmd.emit_ch, cmd.tail && stat.tail_emits}))
    else $error("two result sources in one cycle");

  // a result is only loaded when the output register can take it
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_kw || cmd.emit_ch || (cmd.tail && stat.tail_emits)) |-> stat.out_free)
    else $error("result loaded over an untaken word");

  // a byte is fully handled before the next is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while previous byte pending");

  // halted lexer holds no pending word
  assert property (@(posedge clk) disable iff (!rst_n)
    stat.halted |-> stat.mode_idle)
    else $error("pending word while halted");

endmodule

FILE: sv/klex_ctrl.sv
// klex_ctrl: sequencing state machine of the keyword token lexer
// depends on klex_pkg; drives klex_dp through cmd_t and watches stat_t
module klex_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  klex_pkg::stat_t stat,
  output klex_pkg::cmd_t  cmd
);
  import klex_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_KW, S_RD, S_CH, S_TAIL
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.idx_clr = 1'b1;
        if (!stat.is_end && stat.halted) begin
          state_nxt = S_IDLE;
        end else if (stat.extend) begin
          cmd.append = 1'b1;
          state_nxt  = S_IDLE;
        end else if (stat.mode_idle) begin
          state_nxt = S_TAIL;
        end else if (stat.kw_hit) begin
          state_nxt = S_KW;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_KW: begin
        if (stat.out_free) begin
          cmd.emit_kw = 1'b1;
          state_nxt   = S_TAIL;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CH;
      end
      S_CH: begin
        if (stat.out_free) begin
          cmd.emit_ch = 1'b1;
          state_nxt   = stat.ch_last ? S_TAIL : S_RD;
        end
      end
      S_TAIL: begin
        if (!stat.tail_emits || stat.out_free) begin
          cmd.tail  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/klex_dp.sv
// klex_dp: datapath of the keyword token lexer: held byte, word store, scan state, result word
// depends on klex_pkg; commanded by klex_ctrl
module klex_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  klex_pkg::cmd_t       cmd,
  output klex_pkg::stat_t      stat,
  input  logic [7:0]           in_byte,
  input  logic                 in_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output klex_pkg::kind_t      out_kind,
  output logic [7:0]           out_char,
  output logic                 out_has_text,
  output logic                 out_token_last,
  output logic                 out_truncated,
  output logic                 out_item_last
);
  import klex_pkg::*;

  logic [7:0]        ch_r;
  logic              end_r;
  mode_t             mode_r, mode_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              ovf_r, ovf_nxt;
  logic              halted_r, halted_nxt;
  logic              exit_ok_r, exit_ok_nxt;
  logic              var_ok_r, var_ok_nxt;
  logic              int_ok_r, int_ok_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [7:0]        rd_data_r;
  logic [7:0]        mem [MAX_WORD];

  logic              out_valid_r, out_valid_nxt;
  kind_t             kind_r, kind_nxt;
  logic [7:0]        char_r, char_nxt;
  logic              has_r, has_nxt;
  logic              tlast_r, tlast_nxt;
  logic              trunc_r, trunc_nxt;
  logic              ilast_r, ilast_nxt;

  logic              c_letter, c_digit, c_space, c_single, c_end;
  logic [LEN_W-1:0]  base_len;
  logic              base_ovf, base_exit, base_var, base_int;
  logic              wr_go, wr_en, has_room;
  logic              exit_hit;

  assign c_letter = is_letter(ch_r);
  assign c_digit  = is_digit(ch_r);
  assign c_space  = is_space(ch_r);
  assign c_single = is_single(ch_r);
  assign c_end    = end_r || (ch_r == 8'd0);
  assign exit_hit = exit_ok_r && (len_r == LEN_W'(4));

  always_comb begin
    stat.is_end     = c_end;
    stat.halted     = halted_r;
    stat.extend     = !c_end && !halted_r &&
                      (((mode_r == MODE_WORD) && (c_letter || c_digit)) ||
                       ((mode_r == MODE_NUM) && c_digit));
    stat.mode_idle  = (mode_r == MODE_IDLE);
    stat.kw_hit     = (mode_r == MODE_WORD) && !ovf_r &&
                      (exit_hit || ((var_ok_r || int_ok_r) && len_r == LEN_W'(3)));
    stat.ch_last    = (LEN_W'(idx_r) + LEN_W'(1)) == len_r;
    stat.tail_emits = c_end || c_single || !(c_letter || c_digit || c_space);
    stat.out_free   = !out_valid_r || out_ready;
  end

  // scan state; the tail command clears the word before the held byte may start a new one
  always_comb begin
    base_len  = cmd.tail ? '0   : len_r;
    base_ovf  = cmd.tail ? 1'b0 : ovf_r;
    base_exit = cmd.tail ? 1'b1 : exit_ok_r;
    base_var  = cmd.tail ? 1'b1 : var_ok_r;
    base_int  = cmd.tail ? 1'b1 : int_ok_r;
    has_room  = base_len < LEN_W'(MAX_WORD);
    wr_go     = cmd.append || (cmd.tail && !c_end && (c_letter || c_digit));
    wr_en     = wr_go && has_room;

    mode_nxt    = mode_r;
    halted_nxt  = halted_r;
    len_nxt     = base_len;
    ovf_nxt     = base_ovf;
    exit_ok_nxt = base_exit;
    var_ok_nxt  = base_var;
    int_ok_nxt  = base_int;

    if (cmd.tail) begin
      mode_nxt = MODE_IDLE;
      if (c_end) begin
        halted_nxt = 1'b0;
      end else if (c_letter) begin
        mode_nxt = MODE_WORD;
      end else if (c_digit) begin
        mode_nxt = MODE_NUM;
      end else if (!c_single && !c_space) begin
        halted_nxt = 1'b1;
      end
    end

    if (wr_go) begin
      if (has_room) begin
        len_nxt     = base_len + LEN_W'(1);
        exit_ok_nxt = base_exit && kw_exit_at(base_len, ch_r);
        var_ok_nxt  = base_var && kw_var_at(base_len, ch_r);
        int_ok_nxt  = base_int && kw_int_at(base_len, ch_r);
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.emit_ch) begin
      idx_nxt = idx_r + ADDR_W'(1);
    end
  end

  // result word
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    char_nxt      = char_r;
    has_nxt       = has_r;
    tlast_nxt     = tlast_r;
    trunc_nxt     = trunc_r;
    ilast_nxt     = ilast_r;
    if (cmd.emit_kw) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = exit_hit ? TK_EXIT : (var_ok_r ? TK_VAR : TK_INT);
      char_nxt      = 8'd0;
      has_nxt       = 1'b0;
      tlast_nxt     = 1'b1;
      trunc_nxt     = 1'b0;
      ilast_nxt     = !stat.tail_emits;
    end else if (cmd.emit_ch) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = (mode_r == MODE_WORD) ? TK_IDENT : TK_INTLIT;
      char_nxt      = rd_data_r;
      has_nxt       = 1'b1;
      tlast_nxt     = stat.ch_last;
      trunc_nxt     = ovf_r;
      ilast_nxt     = stat.ch_last && !stat.tail_emits;
    end else if (cmd.tail && stat.tail_emits) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = c_end ? TK_END : single_kind(ch_r);
      char_nxt      = 8'd0;
      has_nxt       = 1'b0;
      tlast_nxt     = 1'b1;
      trunc_nxt     = 1'b0;
      ilast_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      halted_r    <= 1'b0;
      exit_ok_r   <= 1'b1;
      var_ok_r    <= 1'b1;
      int_ok_r    <= 1'b1;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      halted_r    <= halted_nxt;
      exit_ok_r   <= exit_ok_nxt;
      var_ok_r    <= var_ok_nxt;
      int_ok_r    <= int_ok_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ch_r  <= in_byte;
      end_r <= in_end;
    end
    kind_r  <= kind_nxt;
    char_r  <= char_nxt;
    has_r   <= has_nxt;
    tlast_r <= tlast_nxt;
    trunc_r <= trunc_nxt;
    ilast_r <= ilast_nxt;
  end

  // word store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[base_len[ADDR_W-1:0]] <= ch_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[idx_r];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_char       = char_r;
  assign out_has_text   = has_r;
  assign out_token_last = tlast_r;
  assign out_truncated  = trunc_r;
  assign out_item_last  = ilast_r;

endmodule

FILE: dv/tb_keyword_token_lexer.sv
// tb_keyword_token_lexer: self-checking testbench for the keyword token lexer, with its own
// token predictor, directed and random byte streams and random stalls on both sides
// depends on klex_pkg and keyword_token_lexer
module tb_keyword_token_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  import klex_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    kind_t      kind;
    logic [7:0] text;
    bit         has_text;
    bit         tok_last;
    bit         trunc;
    bit         item_last;
  } token_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;    // [7:0] char_byte
  logic       in_tlast = 1'b0;    // is_end
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] text_char
  logic [6:0] out_tuser;          // [3:0] token_kind, [4] has_text, [5] truncated, [6] item_last
  logic       out_tlast;          // token_last

  keyword_token_lexer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // predictor state
  mode_t      lex_mode = MODE_IDLE;
  logic [7:0] word_buf [MAX_WORD];
  int         word_len = 0;
  bit         word_over = 1'b0;
  bit         lex_halted = 1'b0;

  token_t step_tokens[$];
  token_t pending_tokens[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  bytes_sent = 0;
  int  tokens_checked = 0;
  int  trunc_checked = 0;
  int  ends_sent = 0;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;
  int  rx_hold = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic bit alpha_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit blank_ch(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void add_token(kind_t k, logic [7:0] ch, bit has, bit tl, bit tr);
    token_t t;
    t.kind      = k;
    t.text      = ch;
    t.has_text  = has;
    t.tok_last  = tl;
    t.trunc     = tr;
    t.item_last = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endfunction

  function automatic bit word_is(string s);
    if (word_over || word_len != s.len()) return 1'b0;
    for (int i = 0; i < word_len; i++)
      if (word_buf[i] != s[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void add_char(logic [7:0] c);
    if (word_len < MAX_WORD) begin
      word_buf[word_len] = c;
      word_len++;
    end else begin
      word_over = 1'b1;
    end
  endfunction

  function automatic void replay_word(kind_t k);
    for (int i = 0; i < word_len; i++)
      add_token(k, word_buf[i], 1'b1, i + 1 == word_len, word_over);
  endfunction

  function automatic void close_word();
    if (lex_mode == MODE_WORD) begin
      if (word_is("exit")) add_token(TK_EXIT, 8'd0, 1'b0, 1'b1, 1'b0);
      else if (word_is("var")) add_token(TK_VAR, 8'd0, 1'b0, 1'b1, 1'b0);
      else if (word_is("int")) add_token(TK_INT, 8'd0, 1'b0, 1'b1, 1'b0);
      else replay_word(TK_IDENT);
    end else if (lex_mode == MODE_NUM) begin
      replay_word(TK_INTLIT);
    end
    lex_mode  = MODE_IDLE;
    word_len  = 0;
    word_over = 1'b0;
  endfunction

  // works out the tokens that one accepted byte causes and queues them
  function automatic void lexer_predict(logic [7:0] c, bit is_end);
    step_tokens.delete();
    if (is_end || c == 8'd0) begin
      close_word();
      add_token(TK_END, 8'd0, 1'b0, 1'b1, 1'b0);
      lex_halted = 1'b0;
    end else if (!lex_halted) begin
      if (lex_mode == MODE_WORD && (alpha_ch(c) || digit_ch(c))) begin
        add_char(c);
      end else if (lex_mode == MODE_NUM && digit_ch(c)) begin
        add_char(c);
      end else begin
        close_word();
        if (alpha_ch(c)) begin
          lex_mode = MODE_WORD;
          add_char(c);
        end else if (digit_ch(c)) begin
          lex_mode = MODE_NUM;
          add_char(c);
        end else begin
          case (c)
            ";": add_token(TK_SEMI, 8'd0, 1'b0, 1'b1, 1'b0);
            "(": add_token(TK_LPAREN, 8'd0, 1'b0, 1'b1, 1'b0);
            ")": add_token(TK_RPAREN, 8'd0, 1'b0, 1'b1, 1'b0);
            "=": add_token(TK_EQ, 8'd0, 1'b0, 1'b1, 1'b0);
            ":": add_token(TK_COLON, 8'd0, 1'b0, 1'b1, 1'b0);
            "+": add_token(TK_PLUS, 8'd0, 1'b0, 1'b1, 1'b0);
            default: begin
              if (!blank_ch(c)) begin
                add_token(TK_ERROR, 8'd0, 1'b0, 1'b1, 1'b0);
                lex_halted = 1'b1;
              end
            end
          endcase
        end
      end
    end
    if (step_tokens.size() > 0) step_tokens[$].item_last = 1'b1;
    pending_tokens = {pending_tokens, step_tokens};
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic check_token();
    token_t want;
    if (pending_tokens.size() == 0) begin
      report_mismatch("unexpected word, kind", int'(out_tuser[3:0]), -1);
    end else begin
      want = pending_tokens.pop_front();
      if (out_tuser[3:0] !== want.kind)
        report_mismatch("token_kind", int'(out_tuser[3:0]), int'(want.kind));
      if (out_tdata !== want.text)
        report_mismatch("text_char", int'(out_tdata), int'(want.text));
      if (out_tuser[4] !== want.has_text)
        report_mismatch("has_text", int'(out_tuser[4]), int'(want.has_text));
      if (out_tlast !== want.tok_last)
        report_mismatch("token_last", int'(out_tlast), int'(want.tok_last));
      if (out_tuser[5] !== want.trunc)
        report_mismatch("truncated", int'(out_tuser[5]), int'(want.trunc));
      if (out_tuser[6] !== want.item_last)
        report_mismatch("item_last", int'(out_tuser[6]), int'(want.item_last));
      if (want.trunc) trunc_checked++;
    end
    tokens_checked++;
  endtask

  // result side: checks each word taken and drives ready with stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) check_token();
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else if (rx_idle_en && stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input bit is_end);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= is_end;
    do @(posedge clk); while (!in_tready);
    lexer_predict(c, is_end);
    bytes_sent++;
    if (is_end || c == 8'd0) ends_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) != 0) ? 8'("a" + $urandom_range(0, 25))
                                       : 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 0) ? 8'd32 : 8'(8 + r);
  endfunction

  function automatic logic [7:0] rand_punct();
    string p;
    p = ";()=:+";
    return p[$urandom_range(0, 5)];
  endfunction

  function automatic logic [7:0] rand_bad_byte();
    string p;
    p = "!\"#$%&'*,-./<>?@[\\]^_`{|}~";
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(128, 255));
      1: return p[$urandom_range(0, p.len() - 1)];
      default: return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 8))
                                                  : 8'($urandom_range(14, 31));
    endcase
  endfunction

  task automatic send_word(int len, bit numeric);
    for (int i = 0; i < len; i++) begin
      if (numeric) send_byte(rand_digit(), 1'b0);
      else if (i == 0 || $urandom_range(0, 3) != 0) send_byte(rand_letter(), 1'b0);
      else send_byte(rand_digit(), 1'b0);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_phrase();
    string near [7];
    int    r;
    near = '{"exi", "exits", "va", "vars", "in", "Int", "integer"};
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 4))
        0: send_text("exit");
        1: send_text("var");
        2: send_text("int");
        default: send_text(near[$urandom_range(0, 6)]);
      endcase
    end else if (r < 40) begin
      send_word(($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8),
                1'b0);
    end else if (r < 55) begin
      send_word(($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6),
                1'b1);
    end else if (r < 75) begin
      send_byte(rand_punct(), 1'b0);
    end else if (r < 90) begin
      repeat ($urandom_range(1, 3)) send_byte(rand_blank(), 1'b0);
    end else if (r < 94) begin
      send_byte(rand_bad_byte(), 1'b0);
    end else if (r < 98) begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_byte(8'd0, 1'b0);
    end
    // words are often followed straight by a delimiter, sometimes by another word
    case ($urandom_range(0, 3))
      0: send_byte(rand_blank(), 1'b0);
      1: send_byte(rand_punct(), 1'b0);
      default: ;
    endcase
  endtask

  task automatic test_keywords();
    send_text("exit var int;");
    send_text("Exit intx:");
    send_byte(8'h41, 1'b1);
  endtask

  task automatic test_punctuation();
    send_text("(a=1)+");
    send_byte(8'd9, 1'b0);
    send_byte(8'd10, 1'b0);
    send_byte(8'd11, 1'b0);
    send_byte(8'd12, 1'b0);
    send_byte(8'd13, 1'b0);
    send_text(" ;");
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_numbers();
    send_text("12ab 0099");
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_errors();
    send_text("x@yz");
    send_byte(8'hFF, 1'b0);
    send_text("(");
    send_byte(8'h80, 1'b1);
    send_text("1");
    send_byte(8'h80, 1'b0);
    send_text("q");
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_long_words();
    send_word(MAX_WORD, 1'b0);
    send_text(" exit");
    send_word(MAX_WORD - 3, 1'b0);
    send_text(";");
    send_word(MAX_WORD + 8, 1'b0);
    send_text("=");
    send_word(MAX_WORD + 1, 1'b1);
    send_byte(8'd0, 1'b1);
  endtask

  task automatic test_backpressure();
    rx_hold = 300;
    repeat (2) begin
      send_word(10, 1'b0);
      send_text("+");
      send_word(6, 1'b1);
      send_text(";");
    end
    wait_drained();
  endtask

  task automatic test_random(int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) send_phrase();
    send_byte(8'd0, 1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_keywords();
    test_punctuation();
    test_numbers();
    test_errors();
    test_long_words();
    test_backpressure();
    test_random(30);
    wait_drained();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random(12);

    in_tvalid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_tokens.size() != 0)
      report_mismatch("tokens still pending", 0, pending_tokens.size());

    $display("run sent %0d source bytes in %0d texts, checked %0d tokens (%0d truncated)",
             bytes_sent, ends_sent, tokens_checked, trunc_checked);
    $display("with keywords, punctuation, errors, long words and stalls on both sides");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: keyword_token_lexer.f
sv/klex_pkg.sv
sv/klex_ctrl.sv
sv/klex_dp.sv
sv/keyword_token_lexer.sv
dv/tb_keyword_token_lexer.sv
